/* hdl/jet_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jet_pkg: shared types and constants of the julia escape time unit
// Transaction payloads, register indexes, the unit request/response structs
// and the saturating 64-bit add and subtract.
// ----------------------------------------------------------------------------
package jet_pkg;

  localparam int unsigned COUNT_WIDTH    = 16;
  localparam int unsigned DEF_FRAC_BITS  = 28;
  localparam int unsigned IN_WIDTH       = 32;
  localparam int unsigned WORD_WIDTH     = 64;
  localparam int unsigned MOD_WIDTH      = 48;
  localparam int unsigned APB_DATA_WIDTH = 32;
  localparam int unsigned APB_ADDR_WIDTH = 4;

  localparam logic [COUNT_WIDTH-1:0] LIMIT_RESET = COUNT_WIDTH'(256);
  localparam logic [MOD_WIDTH-1:0]   MOD_MAX     = '1;

  localparam logic signed [WORD_WIDTH-1:0] WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
  localparam logic signed [WORD_WIDTH-1:0] WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {
    REG_LIMIT      = 2'd0,
    REG_CONST_REAL = 2'd1,
    REG_CONST_IMAG = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic signed [IN_WIDTH-1:0] start_real;
    logic signed [IN_WIDTH-1:0] start_imag;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] escape_count;
    logic [MOD_WIDTH-1:0]   final_modulus;
  } out_item_t;

  typedef struct packed {
    logic                         start;
    logic signed [WORD_WIDTH-1:0] op_a;
    logic signed [WORD_WIDTH-1:0] op_b;
  } mul_req_t;

  typedef struct packed {
    logic                         done;
    logic signed [WORD_WIDTH-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic                  start;
    logic [WORD_WIDTH-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic                 done;
    logic [MOD_WIDTH-1:0] root;
  } sqrt_rsp_t;

  function automatic logic signed [WORD_WIDTH-1:0] sat_add(
    input logic signed [WORD_WIDTH-1:0] a,
    input logic signed [WORD_WIDTH-1:0] b
  );
    logic signed [WORD_WIDTH-1:0] sum;
    sum = a + b;
    if ((a[WORD_WIDTH-1] == b[WORD_WIDTH-1]) && (sum[WORD_WIDTH-1] != a[WORD_WIDTH-1])) begin
      return a[WORD_WIDTH-1] ? WORD_MIN : WORD_MAX;
    end
    return sum;
  endfunction

  function automatic logic signed [WORD_WIDTH-1:0] sat_sub(
    input logic signed [WORD_WIDTH-1:0] a,
    input logic signed [WORD_WIDTH-1:0] b
  );
    logic signed [WORD_WIDTH-1:0] diff;
    diff = a - b;
    if ((a[WORD_WIDTH-1] != b[WORD_WIDTH-1]) && (diff[WORD_WIDTH-1] != a[WORD_WIDTH-1])) begin
      return a[WORD_WIDTH-1] ? WORD_MIN : WORD_MAX;
    end
    return diff;
  endfunction

endpackage

/* hdl/jet_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jet_mul: shared fixed point multiplier
// Signed 64 x 64 product through one 32 x 32 multiplier, four partial
// products accumulated over cycles, shifted by FRAC_BITS and saturated.
// ----------------------------------------------------------------------------
module jet_mul #(
  parameter int unsigned FRAC_BITS = jet_pkg::DEF_FRAC_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  jet_pkg::mul_req_t req_i,
  output jet_pkg::mul_rsp_t rsp_o
);
  import jet_pkg::*;

  localparam int unsigned HALF_WIDTH = WORD_WIDTH / 2;
  localparam int unsigned PROD_WIDTH = 2 * WORD_WIDTH;

  localparam logic [2:0] PH_LL   = 3'd0;
  localparam logic [2:0] PH_LH   = 3'd1;
  localparam logic [2:0] PH_HL   = 3'd2;
  localparam logic [2:0] PH_HH   = 3'd3;
  localparam logic [2:0] PH_LAST = 3'd4;
  localparam logic [2:0] PH_FIN  = 3'd5;

  logic                         busy_q;
  logic [2:0]                   phase_q;
  logic                         done_q;
  logic                         neg_q;
  logic [WORD_WIDTH-1:0]        ma_q;
  logic [WORD_WIDTH-1:0]        mb_q;
  logic [WORD_WIDTH-1:0]        pp_q;
  logic [WORD_WIDTH-1:0]        pp_d;
  logic [PROD_WIDTH-1:0]        acc_q;
  logic [PROD_WIDTH-1:0]        acc_term;
  logic signed [WORD_WIDTH-1:0] prod_q;
  logic [HALF_WIDTH-1:0]        a_half;
  logic [HALF_WIDTH-1:0]        b_half;
  logic                         ovf;
  logic [WORD_WIDTH-1:0]        mag;
  logic signed [WORD_WIDTH-1:0] fin;

  function automatic logic [WORD_WIDTH-1:0] magnitude(input logic signed [WORD_WIDTH-1:0] v);
    return v[WORD_WIDTH-1] ? (~v + WORD_WIDTH'(1)) : v;
  endfunction

  assign a_half = phase_q[1] ? ma_q[WORD_WIDTH-1:HALF_WIDTH] : ma_q[HALF_WIDTH-1:0];
  assign b_half = phase_q[0] ? mb_q[WORD_WIDTH-1:HALF_WIDTH] : mb_q[HALF_WIDTH-1:0];
  assign pp_d   = a_half * b_half;

  always_comb begin
    unique case (phase_q)
      PH_LH:         acc_term = {{WORD_WIDTH{1'b0}}, pp_q};
      PH_HL, PH_HH:  acc_term = {{HALF_WIDTH{1'b0}}, pp_q, {HALF_WIDTH{1'b0}}};
      PH_LAST:       acc_term = {pp_q, {WORD_WIDTH{1'b0}}};
      default:       acc_term = '0;
    endcase
  end

  always_comb begin
    ovf = |acc_q[PROD_WIDTH-1:WORD_WIDTH+FRAC_BITS];
    mag = acc_q[FRAC_BITS +: WORD_WIDTH];
    if (ovf) begin
      fin = neg_q ? WORD_MIN : WORD_MAX;
    end else if (neg_q) begin
      fin = mag[WORD_WIDTH-1] ? WORD_MIN : $signed(~mag + WORD_WIDTH'(1));
    end else begin
      fin = mag[WORD_WIDTH-1] ? WORD_MAX : $signed(mag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= PH_LL;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q  <= 1'b1;
        phase_q <= PH_LL;
      end else if (busy_q) begin
        if (phase_q == PH_FIN) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          phase_q <= phase_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.op_a[WORD_WIDTH-1] ^ req_i.op_b[WORD_WIDTH-1];
      ma_q  <= magnitude(req_i.op_a);
      mb_q  <= magnitude(req_i.op_b);
      acc_q <= '0;
    end else if (busy_q) begin
      pp_q  <= pp_d;
      acc_q <= acc_q + acc_term;
      if (phase_q == PH_FIN) begin
        prod_q <= fin;
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = prod_q;

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("multiplier started while busy");

  a_fin_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !req_i.start && phase_q == PH_FIN) |=> (done_q && !busy_q))
    else $error("multiplier missed its done pulse");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("multiplier done held longer than one cycle");
`endif

endmodule

/* hdl/jet_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jet_sqrt: fixed point square root
// Floor of sqrt(radicand * 2^FRAC_BITS), one root bit per cycle by the
// digit-by-digit method, saturated to the modulus field.
// ----------------------------------------------------------------------------
module jet_sqrt #(
  parameter int unsigned FRAC_BITS = jet_pkg::DEF_FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  jet_pkg::sqrt_req_t req_i,
  output jet_pkg::sqrt_rsp_t rsp_o
);
  import jet_pkg::*;

  localparam int unsigned RAD_WIDTH  = WORD_WIDTH + FRAC_BITS;
  localparam int unsigned RAD_EVEN   = RAD_WIDTH + (RAD_WIDTH % 2);
  localparam int unsigned ROOT_WIDTH = RAD_EVEN / 2;
  localparam int unsigned REM_WIDTH  = ROOT_WIDTH + 3;
  localparam int unsigned STEP_WIDTH = $clog2(ROOT_WIDTH);
  localparam logic [STEP_WIDTH-1:0] STEP_LAST = STEP_WIDTH'(ROOT_WIDTH - 1);

  logic                  busy_q;
  logic                  done_q;
  logic [STEP_WIDTH-1:0] step_q;
  logic [RAD_EVEN-1:0]   rad_q;
  logic [RAD_EVEN-1:0]   rad_d;
  logic [REM_WIDTH-1:0]  rem_q;
  logic [REM_WIDTH-1:0]  rem_d;
  logic [REM_WIDTH-1:0]  rem_sh;
  logic [REM_WIDTH-1:0]  trial;
  logic [ROOT_WIDTH-1:0] root_q;
  logic [ROOT_WIDTH-1:0] root_d;
  logic                  fit;
  logic [MOD_WIDTH-1:0]  res_q;
  logic [MOD_WIDTH-1:0]  res_d;

  always_comb begin
    rem_sh = {rem_q[REM_WIDTH-3:0], rad_q[RAD_EVEN-1 -: 2]};
    trial  = REM_WIDTH'({root_q, 2'b01});
    fit    = (rem_sh >= trial);
    rem_d  = fit ? (rem_sh - trial) : rem_sh;
    root_d = {root_q[ROOT_WIDTH-2:0], fit};
    rad_d  = {rad_q[RAD_EVEN-3:0], 2'b00};
    if (WORD_WIDTH'(root_d) > WORD_WIDTH'(MOD_MAX)) begin
      res_d = MOD_MAX;
    end else begin
      res_d = MOD_WIDTH'(root_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_WIDTH'(1);
        if (step_q == STEP_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rad_q  <= RAD_EVEN'({req_i.radicand, {FRAC_BITS{1'b0}}});
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
      if (step_q == STEP_LAST) begin
        res_q <= res_d;
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = res_q;

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("square root started while busy");

  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !req_i.start && step_q == STEP_LAST) |=> (done_q && !busy_q))
    else $error("square root missed its done pulse");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("square root done held longer than one cycle");
`endif

endmodule

/* hdl/julia_escape_time_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// julia_escape_time_unit: julia set escape time for one start point
// Iterates z = z*z + c in saturating Q36.28 and returns the escape count and
// the modulus of z after two more iterations, or zeros for a point that reaches the limit.
// ----------------------------------------------------------------------------
// One input transaction is processed at a time. Each complex iteration uses
// three 64-bit products on a single shared 32 x 32 multiplier (four partial
// products per product), plus an update and an escape test step. An
// escaping point then runs two extra iterations and a one-bit-per-cycle
// square root of (64 + FRAC_BITS) / 2 steps. A finished result waits in an
// output register, and the next point is accepted while it does. The user
// must write configuration through the APB port only while the unit is
// idle; the unit itself does not enforce this.
module julia_escape_time_unit #(
  parameter int unsigned FRAC_BITS = jet_pkg::DEF_FRAC_BITS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [jet_pkg::APB_ADDR_WIDTH-1:0]     paddr,
  input  logic [jet_pkg::APB_DATA_WIDTH-1:0]     pwdata,
  output logic [jet_pkg::APB_DATA_WIDTH-1:0]     prdata,
  output logic                                   pready,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  jet_pkg::in_item_t                      in_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output jet_pkg::out_item_t                     out_data_o
);
  import jet_pkg::*;

  localparam logic signed [WORD_WIDTH-1:0] RADIUS2 = WORD_WIDTH'(16) << FRAC_BITS;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SQX  = 8'b0000_0010,
    S_SQY  = 8'b0000_0100,
    S_TEST = 8'b0000_1000,
    S_XY   = 8'b0001_0000,
    S_UPD  = 8'b0010_0000,
    S_SQRT = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

  state_e                       state_q, state_d;
  logic                         wait_q, wait_d;
  logic                         tail_q, tail_d;
  logic                         extra_q, extra_d;
  logic [COUNT_WIDTH-1:0]       count_q, count_d;
  logic                         out_valid_q, out_valid_d;
  out_item_t                    out_q, out_d;
  logic signed [WORD_WIDTH-1:0] x_q, x_d;
  logic signed [WORD_WIDTH-1:0] y_q, y_d;
  logic signed [WORD_WIDTH-1:0] x2_q, x2_d;
  logic signed [WORD_WIDTH-1:0] y2_q, y2_d;
  logic [COUNT_WIDTH-1:0]       res_count_q, res_count_d;
  logic [MOD_WIDTH-1:0]         res_mod_q, res_mod_d;

  logic [COUNT_WIDTH-1:0]       limit_q;
  logic signed [IN_WIDTH-1:0]   const_real_q;
  logic signed [IN_WIDTH-1:0]   const_imag_q;
  logic signed [WORD_WIDTH-1:0] cr_ext;
  logic signed [WORD_WIDTH-1:0] ci_ext;
  logic signed [WORD_WIDTH-1:0] mod2;
  logic                         cfg_wr;

  mul_req_t  mul_req;
  mul_rsp_t  mul_rsp;
  sqrt_req_t sqrt_req;
  sqrt_rsp_t sqrt_rsp;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q      <= LIMIT_RESET;
      const_real_q <= '0;
      const_imag_q <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_LIMIT:      limit_q      <= pwdata[COUNT_WIDTH-1:0];
        REG_CONST_REAL: const_real_q <= $signed(pwdata[IN_WIDTH-1:0]);
        REG_CONST_IMAG: const_imag_q <= $signed(pwdata[IN_WIDTH-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LIMIT:      prdata = APB_DATA_WIDTH'(limit_q);
      REG_CONST_REAL: prdata = APB_DATA_WIDTH'(const_real_q);
      REG_CONST_IMAG: prdata = APB_DATA_WIDTH'(const_imag_q);
      default:        prdata = '0;
    endcase
  end

  assign cr_ext = {{(WORD_WIDTH-IN_WIDTH){const_real_q[IN_WIDTH-1]}}, const_real_q};
  assign ci_ext = {{(WORD_WIDTH-IN_WIDTH){const_imag_q[IN_WIDTH-1]}}, const_imag_q};
  assign mod2   = sat_add(x2_q, y2_q);

  // sequencer
  always_comb begin
    state_d     = state_q;
    wait_d      = wait_q;
    tail_d      = tail_q;
    extra_d     = extra_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    x_d         = x_q;
    y_d         = y_q;
    x2_d        = x2_q;
    y2_d        = y2_q;
    res_count_d = res_count_q;
    res_mod_d   = res_mod_q;

    mul_req.start     = 1'b0;
    mul_req.op_a      = (state_q == S_SQY) ? y_q : x_q;
    mul_req.op_b      = (state_q == S_SQX) ? x_q : y_q;
    sqrt_req.start    = 1'b0;
    sqrt_req.radicand = mod2[WORD_WIDTH-1] ? '0 : mod2;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          x_d     = {{(WORD_WIDTH-IN_WIDTH){in_data_i.start_real[IN_WIDTH-1]}},
                     in_data_i.start_real};
          y_d     = {{(WORD_WIDTH-IN_WIDTH){in_data_i.start_imag[IN_WIDTH-1]}},
                     in_data_i.start_imag};
          count_d = COUNT_WIDTH'(1);
          tail_d  = 1'b0;
          extra_d = 1'b0;
          wait_d  = 1'b0;
          state_d = S_SQX;
        end
      end
      S_SQX: begin
        if (!wait_q) begin
          mul_req.start = 1'b1;
          wait_d        = 1'b1;
        end else if (mul_rsp.done) begin
          x2_d    = mul_rsp.prod;
          wait_d  = 1'b0;
          state_d = S_SQY;
        end
      end
      S_SQY: begin
        if (!wait_q) begin
          mul_req.start = 1'b1;
          wait_d        = 1'b1;
        end else if (mul_rsp.done) begin
          y2_d   = mul_rsp.prod;
          wait_d = 1'b0;
          if (!tail_q) begin
            state_d = S_TEST;
          end else if (extra_q) begin
            state_d = S_SQRT;
          end else begin
            extra_d = 1'b1;
            state_d = S_XY;
          end
        end
      end
      S_TEST: begin
        if (mod2 < RADIUS2) begin
          if (count_q < limit_q) begin
            count_d = count_q + COUNT_WIDTH'(1);
            state_d = S_XY;
          end else begin
            res_count_d = '0;
            res_mod_d   = '0;
            state_d     = S_DONE;
          end
        end else if (count_q >= limit_q) begin
          res_count_d = '0;
          res_mod_d   = '0;
          state_d     = S_DONE;
        end else begin
          tail_d  = 1'b1;
          state_d = S_XY;
        end
      end
      S_XY: begin
        if (!wait_q) begin
          mul_req.start = 1'b1;
          wait_d        = 1'b1;
        end else if (mul_rsp.done) begin
          wait_d  = 1'b0;
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        x_d     = sat_add(sat_sub(x2_q, y2_q), cr_ext);
        y_d     = sat_add(sat_add(mul_rsp.prod, mul_rsp.prod), ci_ext);
        state_d = S_SQX;
      end
      S_SQRT: begin
        if (!wait_q) begin
          sqrt_req.start = 1'b1;
          wait_d         = 1'b1;
        end else if (sqrt_rsp.done) begin
          res_count_d = count_q;
          res_mod_d   = sqrt_rsp.root;
          wait_d      = 1'b0;
          state_d     = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d         = 1'b1;
          out_d.escape_count  = res_count_q;
          out_d.final_modulus = res_mod_q;
          state_d             = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wait_q      <= 1'b0;
      tail_q      <= 1'b0;
      extra_q     <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wait_q      <= wait_d;
      tail_q      <= tail_d;
      extra_q     <= extra_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q       <= out_d;
    x_q         <= x_d;
    y_q         <= y_d;
    x2_q        <= x2_d;
    y2_q        <= y2_d;
    res_count_q <= res_count_d;
    res_mod_q   <= res_mod_d;
  end

  jet_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mul_req),
    .rsp_o (mul_rsp)
  );

  jet_sqrt #(
    .FRAC_BITS(FRAC_BITS)
  ) u_sqrt (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (sqrt_req),
    .rsp_o (sqrt_rsp)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_SQX && !wait_q))
    else $error("accepted transaction did not start with the square of x");

  a_mul_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> (wait_q && (state_q == S_SQX || state_q == S_SQY || state_q == S_XY)))
    else $error("product returned while the sequencer was not waiting for it");

  a_sqrt_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_rsp.done |=> state_q == S_DONE)
    else $error("square root result not handed to the output stage");

  a_inside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.escape_count != '0 || out_data_o.final_modulus == '0))
    else $error("nonzero modulus reported for a point that did not escape");
`endif

endmodule
